// File: design/rbj_pkg.sv
// Shared widths, codes, constants and word types of the retry backoff block.
package rbj_pkg;

    localparam int DELAY_WIDTH     = 32;
    localparam int ATTEMPT_WIDTH   = 8;
    localparam int FRACTION_BITS   = 16;
    localparam int MULT_WIDTH      = FRACTION_BITS + 8;
    localparam int RATIO_WIDTH     = FRACTION_BITS + 1;
    localparam int GEN_WIDTH       = 64;
    localparam int UNIT_BITS       = 53;
    localparam int RAND_DROP       = GEN_WIDTH - UNIT_BITS;
    localparam int MAG_WIDTH       = UNIT_BITS + 1;
    localparam int FACTOR_WIDTH    = UNIT_BITS + 2;
    localparam int MUL_WIDTH       = 64;
    localparam int PROD_WIDTH      = 2 * MUL_WIDTH;
    localparam int DIGIT_BITS_DEFAULT = 8;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 64;

    localparam int MIX_SHIFT1 = 30;
    localparam int MIX_SHIFT2 = 27;
    localparam int MIX_SHIFT3 = 31;

    localparam logic [GEN_WIDTH-1:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [GEN_WIDTH-1:0] MIX_MUL1     = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [GEN_WIDTH-1:0] MIX_MUL2     = 64'h94d0_49bb_1331_11eb;

    localparam logic [ATTEMPT_WIDTH-1:0] RST_MAX_ATTEMPTS = ATTEMPT_WIDTH'(3);
    localparam logic [DELAY_WIDTH-1:0]   RST_INITIAL      = DELAY_WIDTH'(1000);
    localparam logic [MULT_WIDTH-1:0]    RST_MULTIPLIER   = MULT_WIDTH'(2) << FRACTION_BITS;
    localparam logic [DELAY_WIDTH-1:0]   RST_MAX_BACKOFF  = DELAY_WIDTH'(1000000);
    localparam logic [RATIO_WIDTH-1:0]   RST_RATIO        = '0;
    localparam logic [GEN_WIDTH-1:0]     RST_GEN          = '0;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_CONN_FAIL,
        STATUS_INTERNAL,
        STATUS_OTHER
    } t_status;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_MAX_ATTEMPTS,
        REG_INITIAL_BACKOFF,
        REG_MULTIPLIER,
        REG_MAX_BACKOFF,
        REG_JITTER_RATIO,
        REG_RANDOM_SEED
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GROW,
        ST_GROW_WAIT,
        ST_JITTER,
        ST_MIX1_WAIT,
        ST_MIX2_WAIT,
        ST_MAG_WAIT,
        ST_SCALE_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_status                  status_code;
        logic [ATTEMPT_WIDTH-1:0] attempt_count;
    } t_in_word;

    typedef struct packed {
        logic                   should_retry;
        logic [DELAY_WIDTH-1:0] backoff_us;
    } t_out_word;

    typedef struct packed {
        logic [ATTEMPT_WIDTH-1:0] attempt_limit;
        logic [DELAY_WIDTH-1:0]   first_delay;
        logic [MULT_WIDTH-1:0]    multiplier;
        logic [DELAY_WIDTH-1:0]   delay_limit;
        logic [RATIO_WIDTH-1:0]   jitter_frac;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [MUL_WIDTH-1:0] a;
        logic [MUL_WIDTH-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                  done;
        logic [PROD_WIDTH-1:0] product;
    } t_mul_rsp;

endpackage

// File: design/rbj_serial_mul.sv
// Digit-serial shift-add multiplier, full 128-bit product of two 64-bit operands.
module rbj_serial_mul
    import rbj_pkg::*;
#(
    parameter int DIGIT_BITS = DIGIT_BITS_DEFAULT
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int STEPS     = MUL_WIDTH / DIGIT_BITS;
    localparam int CNT_WIDTH = $clog2(STEPS + 1);
    localparam int SUM_WIDTH = MUL_WIDTH + DIGIT_BITS;

    logic [MUL_WIDTH-1:0] r_a, n_a;
    logic [MUL_WIDTH-1:0] r_b, n_b;
    logic [MUL_WIDTH-1:0] r_acc, n_acc;
    logic [MUL_WIDTH-1:0] r_lo, n_lo;
    logic [CNT_WIDTH-1:0] r_cnt, n_cnt;
    logic                 r_done, n_done;
    logic [SUM_WIDTH-1:0] sum;

    // one multiplier digit per cycle, LSB first; low product bits shift into r_lo
    always_comb begin
        sum = SUM_WIDTH'(r_acc)
            + SUM_WIDTH'(r_a) * SUM_WIDTH'(r_b[DIGIT_BITS-1:0]);
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_lo   = r_lo;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_req.start) begin
            n_a   = i_req.a;
            n_b   = i_req.b;
            n_acc = '0;
            n_lo  = '0;
            n_cnt = CNT_WIDTH'(STEPS);
        end else if (r_cnt != '0) begin
            n_acc  = sum[SUM_WIDTH-1:DIGIT_BITS];
            n_lo   = {sum[DIGIT_BITS-1:0], r_lo[MUL_WIDTH-1:DIGIT_BITS]};
            n_b    = r_b >> DIGIT_BITS;
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == CNT_WIDTH'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_lo  <= n_lo;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = {r_acc, r_lo};

endmodule

// File: design/rbj_cfg_regs.sv
// Configuration registers and the random generator counter.
module rbj_cfg_regs
    import rbj_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                       i_gen_advance,
    output t_cfg                       o_cfg,
    output logic [GEN_WIDTH-1:0]       o_gen_ctr
);

    t_cfg                 r_cfg, n_cfg;
    logic [GEN_WIDTH-1:0] r_gen, n_gen;

    always_comb begin
        n_cfg = r_cfg;
        n_gen = r_gen;
        if (i_gen_advance) begin
            n_gen = r_gen + GOLDEN_GAMMA;
        end
        if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_MAX_ATTEMPTS:    n_cfg.attempt_limit = i_cfg_data[ATTEMPT_WIDTH-1:0];
                REG_INITIAL_BACKOFF: n_cfg.first_delay   = i_cfg_data[DELAY_WIDTH-1:0];
                REG_MULTIPLIER:      n_cfg.multiplier    = i_cfg_data[MULT_WIDTH-1:0];
                REG_MAX_BACKOFF:     n_cfg.delay_limit   = i_cfg_data[DELAY_WIDTH-1:0];
                REG_JITTER_RATIO:    n_cfg.jitter_frac   = i_cfg_data[RATIO_WIDTH-1:0];
                REG_RANDOM_SEED:     n_gen               = i_cfg_data[GEN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attempt_limit <= RST_MAX_ATTEMPTS;
            r_cfg.first_delay   <= RST_INITIAL;
            r_cfg.multiplier    <= RST_MULTIPLIER;
            r_cfg.delay_limit   <= RST_MAX_BACKOFF;
            r_cfg.jitter_frac   <= RST_RATIO;
            r_gen               <= RST_GEN;
        end else begin
            r_cfg <= n_cfg;
            r_gen <= n_gen;
        end
    end

    assign o_cfg     = r_cfg;
    assign o_gen_ctr = r_gen;

endmodule

// File: design/rbj_engine.sv
// Sequencer and datapath: growth loop, splitmix step and jitter scaling on one multiplier.
module rbj_engine
    import rbj_pkg::*;
#(
    parameter int DIGIT_BITS = DIGIT_BITS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in,
    input  t_cfg                 i_cfg,
    input  logic [GEN_WIDTH-1:0] i_gen_ctr,
    output logic                 o_gen_advance,
    output logic                 o_res_valid,
    input  logic                 i_res_take,
    output t_out_word            o_res
);

    localparam logic [MAG_WIDTH-1:0]    HALF_MAG = {1'b1, {UNIT_BITS{1'b0}}};
    localparam logic [FACTOR_WIDTH-1:0] HALF_F   = {2'b01, {UNIT_BITS{1'b0}}};

    t_state                   r_state, n_state;
    logic                     r_retry, n_retry;
    logic [DELAY_WIDTH-1:0]   r_delay, n_delay;
    logic [ATTEMPT_WIDTH-1:0] r_steps, n_steps;
    logic                     r_up, n_up;

    t_mul_req                 mul_req;
    t_mul_rsp                 mul_rsp;
    logic [PROD_WIDTH-1:0]    prod;

    logic                     start_zero;
    logic                     retryable;
    logic                     jitter_on;
    logic [GEN_WIDTH-1:0]     mix_in0;
    logic [GEN_WIDTH-1:0]     mix_word;
    logic [GEN_WIDTH-1:0]     mix_in1;
    logic [GEN_WIDTH-1:0]     rnd;
    logic [UNIT_BITS-1:0]     unit;
    logic                     up;
    logic [MAG_WIDTH-1:0]     mag;
    logic [MAG_WIDTH-1:0]     jm;
    logic [FACTOR_WIDTH-1:0]  factor;
    logic                     grow_ge_cap;
    logic [DELAY_WIDTH-1:0]   grow_lo;
    logic                     scaled_gt_cap;
    logic [DELAY_WIDTH-1:0]   scaled_lo;

    rbj_serial_mul #(
        .DIGIT_BITS(DIGIT_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_rsp  (mul_rsp)
    );

    assign prod = mul_rsp.product;

    assign start_zero = (i_in.attempt_count == '0) || (i_cfg.first_delay == '0);
    assign retryable  = (i_in.status_code == STATUS_CONN_FAIL)
                     || (i_in.status_code == STATUS_INTERNAL);
    assign jitter_on  = (i_cfg.jitter_frac != '0) && (r_delay != '0);

    // splitmix64 output function, spread over two multiplies
    assign mix_in0  = i_gen_ctr ^ (i_gen_ctr >> MIX_SHIFT1);
    assign mix_word = prod[GEN_WIDTH-1:0];
    assign mix_in1  = mix_word ^ (mix_word >> MIX_SHIFT2);
    assign rnd      = mix_word ^ (mix_word >> MIX_SHIFT3);
    assign unit     = rnd[GEN_WIDTH-1:RAND_DROP];

    // |2r - 1.0| in Q.53; when 2r >= 1.0 the top bit simply drops
    assign up  = unit[UNIT_BITS-1];
    assign mag = up ? {1'b0, unit[UNIT_BITS-2:0], 1'b0}
                    : (HALF_MAG - {unit, 1'b0});

    assign jm     = prod[FRACTION_BITS+MAG_WIDTH-1:FRACTION_BITS];
    assign factor = r_up ? (HALF_F + {1'b0, jm})
                         : ((jm >= HALF_MAG) ? '0 : {1'b0, HALF_MAG - jm});

    assign grow_lo       = prod[FRACTION_BITS+DELAY_WIDTH-1:FRACTION_BITS];
    assign grow_ge_cap   = (|prod[PROD_WIDTH-1:FRACTION_BITS+DELAY_WIDTH])
                        || (grow_lo >= i_cfg.delay_limit);
    assign scaled_lo     = prod[UNIT_BITS+DELAY_WIDTH-1:UNIT_BITS];
    assign scaled_gt_cap = (|prod[PROD_WIDTH-1:UNIT_BITS+DELAY_WIDTH])
                        || (scaled_lo > i_cfg.delay_limit);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (i_in_valid) n_state = start_zero ? ST_DONE : ST_GROW;
            ST_GROW:       n_state = (r_steps != '0) ? ST_GROW_WAIT : ST_JITTER;
            ST_GROW_WAIT:  if (mul_rsp.done) n_state = ST_GROW;
            ST_JITTER:     n_state = jitter_on ? ST_MIX1_WAIT : ST_DONE;
            ST_MIX1_WAIT:  if (mul_rsp.done) n_state = ST_MIX2_WAIT;
            ST_MIX2_WAIT:  if (mul_rsp.done) n_state = ST_MAG_WAIT;
            ST_MAG_WAIT:   if (mul_rsp.done) n_state = ST_SCALE_WAIT;
            ST_SCALE_WAIT: if (mul_rsp.done) n_state = ST_DONE;
            ST_DONE:       if (i_res_take) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_retry       = r_retry;
        n_delay       = r_delay;
        n_steps       = r_steps;
        n_up          = r_up;
        mul_req.start = 1'b0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        o_gen_advance = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_retry = retryable
                           && (i_in.attempt_count < i_cfg.attempt_limit);
                    n_delay = start_zero ? '0 : i_cfg.first_delay;
                    n_steps = i_in.attempt_count - 1'b1;
                end
            end
            ST_GROW: begin
                if (r_steps != '0) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_WIDTH'(r_delay);
                    mul_req.b     = MUL_WIDTH'(i_cfg.multiplier);
                    n_steps       = r_steps - 1'b1;
                end else if (r_delay > i_cfg.delay_limit) begin
                    n_delay = i_cfg.delay_limit;
                end
            end
            ST_GROW_WAIT: begin
                if (mul_rsp.done) begin
                    if (grow_ge_cap) begin
                        // reached the cap: growth stops here
                        n_delay = i_cfg.delay_limit;
                        n_steps = '0;
                    end else begin
                        n_delay = grow_lo;
                    end
                end
            end
            ST_JITTER: begin
                if (jitter_on) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mix_in0;
                    mul_req.b     = MIX_MUL1;
                    o_gen_advance = 1'b1;
                end
            end
            ST_MIX1_WAIT: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = mix_in1;
                    mul_req.b     = MIX_MUL2;
                end
            end
            ST_MIX2_WAIT: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_WIDTH'(mag);
                    mul_req.b     = MUL_WIDTH'(i_cfg.jitter_frac);
                    n_up          = up;
                end
            end
            ST_MAG_WAIT: begin
                if (mul_rsp.done) begin
                    mul_req.start = 1'b1;
                    mul_req.a     = MUL_WIDTH'(r_delay);
                    mul_req.b     = MUL_WIDTH'(factor);
                end
            end
            ST_SCALE_WAIT: begin
                if (mul_rsp.done) begin
                    n_delay = scaled_gt_cap ? i_cfg.delay_limit : scaled_lo;
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_retry <= n_retry;
        r_delay <= n_delay;
        r_steps <= n_steps;
        r_up    <= n_up;
    end

    assign o_in_ready         = (r_state == ST_IDLE);
    assign o_res_valid        = (r_state == ST_DONE);
    assign o_res.should_retry = r_retry;
    assign o_res.backoff_us   = r_delay;

endmodule

// File: design/retry_backoff_jitter_core.sv
// Top level: retry decision and truncated exponential backoff with jitter.
//
//   channel  direction  handshake                  word
//   cfg      in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//   in       in         i_in_valid / o_in_ready    i_in_data  (t_in_word)
//   out      out        o_out_valid / i_out_ready  o_out_data (t_out_word)
//
// One word at a time. Every multiply runs on the shared digit-serial
// multiplier: one per growth step, and four more when jitter applies;
// a word with zero attempts or a zero initial delay goes straight to done.
// Reset is synchronous, active low, no clearing pass.
// The result sits in an output register, so the next word is taken while it
// waits; a full output register holds the engine in its done state.
module retry_backoff_jitter_core
    import rbj_pkg::*;
#(
    parameter int DIGIT_BITS = DIGIT_BITS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  t_in_word                   i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output t_out_word                  o_out_data
);

    t_cfg                 cfg;
    logic [GEN_WIDTH-1:0] gen_ctr;
    logic                 gen_advance;
    logic                 res_valid;
    logic                 res_take;
    t_out_word            res;

    logic                 r_out_valid, n_out_valid;
    t_out_word            r_out_data;

    rbj_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_gen_advance(gen_advance),
        .o_cfg        (cfg),
        .o_gen_ctr    (gen_ctr)
    );

    rbj_engine #(
        .DIGIT_BITS(DIGIT_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in_data),
        .i_cfg        (cfg),
        .i_gen_ctr    (gen_ctr),
        .o_gen_advance(gen_advance),
        .o_res_valid  (res_valid),
        .i_res_take   (res_take),
        .o_res        (res)
    );

    assign o_cfg_ready = 1'b1;

    assign res_take = res_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        n_out_valid = r_out_valid;
        if (res_take) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_gen_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gen_advance |-> !o_in_ready)
        else $error("generator advanced while engine idle");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("engine ready right after taking a word");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_take) |=> res_valid)
        else $error("engine result dropped before output register took it");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_take |=> o_out_valid)
        else $error("output register not loaded after result handoff");

endmodule

// File: tb/retry_backoff_jitter_core_tb.sv
// Self-checking testbench for the retry backoff core: directed and random words.
module retry_backoff_jitter_core_tb;
    import rbj_pkg::*;

    localparam int CYCLE_LIMIT     = 6_000_000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 600;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 92;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    t_in_word                   in_word = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    t_out_word                  out_word;

    retry_backoff_jitter_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_word)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // register shadow and generator state
    logic [ATTEMPT_WIDTH-1:0] lim_attempts = RST_MAX_ATTEMPTS;
    logic [DELAY_WIDTH-1:0]   base_delay   = RST_INITIAL;
    logic [MULT_WIDTH-1:0]    growth_q16   = RST_MULTIPLIER;
    logic [DELAY_WIDTH-1:0]   delay_cap    = RST_MAX_BACKOFF;
    logic [RATIO_WIDTH-1:0]   jitter_q16   = RST_RATIO;
    logic [GEN_WIDTH-1:0]     mix_counter  = RST_GEN;

    t_in_word  request_fifo[$];
    t_out_word answer_fifo[$];

    int          error_count    = 0;
    int unsigned cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          pressure_token = 0;
    int          pressure_seen  = 0;
    int          hold_left      = 0;
    logic        in_fire        = 1'b0;

    // floor(a * b / 2^sh), saturating to all ones when it overflows 64 bits
    function automatic logic [63:0] scale_floor(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] prod;
        prod = ({64'd0, a} * {64'd0, b}) >> sh;
        if (prod[127:64] != '0) return '1;
        return prod[63:0];
    endfunction

    function automatic t_out_word predict_answer(t_in_word w);
        t_out_word   ans;
        logic [63:0] delay, cap, v, half, two_r, mag, jm, factor;
        logic        up;
        int          i;
        cap = 64'(delay_cap);
        ans.should_retry = (w.status_code == STATUS_CONN_FAIL ||
                            w.status_code == STATUS_INTERNAL) &&
                           (w.attempt_count < lim_attempts);
        delay = 64'(base_delay);
        if (w.attempt_count == '0 || delay == '0) begin
            delay = '0;
        end else begin
            for (i = 1; i < int'(w.attempt_count); i++) begin
                delay = scale_floor(delay, 64'(growth_q16), FRACTION_BITS);
                if (delay >= cap) begin
                    delay = cap;
                    break;
                end
            end
            if (delay > cap) delay = cap;
            if (jitter_q16 != '0 && delay != '0) begin
                v = mix_counter;
                mix_counter = mix_counter + GOLDEN_GAMMA;
                v = (v ^ (v >> MIX_SHIFT1)) * MIX_MUL1;
                v = (v ^ (v >> MIX_SHIFT2)) * MIX_MUL2;
                v = v ^ (v >> MIX_SHIFT3);
                half  = 64'd1 << UNIT_BITS;
                two_r = (v >> RAND_DROP) << 1;
                up    = two_r >= half;
                mag   = up ? two_r - half : half - two_r;
                jm    = scale_floor(mag, 64'(jitter_q16), FRACTION_BITS);
                if (up) factor = half + jm;
                else factor = (jm >= half) ? 64'd0 : half - jm;
                delay = scale_floor(delay, factor, UNIT_BITS);
                if (delay > cap) delay = cap;
            end
        end
        ans.backoff_us = delay[DELAY_WIDTH-1:0];
        return ans;
    endfunction

    // input side: predict on every accepted word
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            answer_fifo.push_back(predict_answer(in_word));
            in_fire <= 1'b1;
        end else begin
            in_fire <= 1'b0;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (request_fifo.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                in_valid <= 1'b1;
                in_word  <= request_fifo.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (pressure_token != pressure_seen) begin
            // long back-pressure so the core fills and stalls its input
            pressure_seen <= pressure_token;
            hold_left     <= HOLD_CYCLES;
            out_ready     <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (answer_fifo.size() == 0) begin
                $error("unexpected result word: should_retry %0d backoff_us %0d",
                       out_word.should_retry, out_word.backoff_us);
                error_count++;
            end else begin
                want = answer_fifo.pop_front();
                if (out_word.should_retry !== want.should_retry) begin
                    $error("should_retry: expected %0d, got %0d",
                           want.should_retry, out_word.should_retry);
                    error_count++;
                end
                if (out_word.backoff_us !== want.backoff_us) begin
                    $error("backoff_us: expected %0d, got %0d",
                           want.backoff_us, out_word.backoff_us);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_WIDTH-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MAX_ATTEMPTS:    lim_attempts = value[ATTEMPT_WIDTH-1:0];
            REG_INITIAL_BACKOFF: base_delay   = value[DELAY_WIDTH-1:0];
            REG_MULTIPLIER:      growth_q16   = value[MULT_WIDTH-1:0];
            REG_MAX_BACKOFF:     delay_cap    = value[DELAY_WIDTH-1:0];
            REG_JITTER_RATIO:    jitter_q16   = value[RATIO_WIDTH-1:0];
            REG_RANDOM_SEED:     mix_counter  = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(logic [ATTEMPT_WIDTH-1:0] ma, logic [DELAY_WIDTH-1:0] ib,
                                logic [MULT_WIDTH-1:0] mult, logic [DELAY_WIDTH-1:0] cap,
                                logic [RATIO_WIDTH-1:0] ratio, logic [GEN_WIDTH-1:0] seed);
        write_reg(REG_MAX_ATTEMPTS, 64'(ma));
        write_reg(REG_INITIAL_BACKOFF, 64'(ib));
        write_reg(REG_MULTIPLIER, 64'(mult));
        write_reg(REG_MAX_BACKOFF, 64'(cap));
        write_reg(REG_JITTER_RATIO, 64'(ratio));
        write_reg(REG_RANDOM_SEED, seed);
    endtask

    task automatic queue_word(t_status s, logic [ATTEMPT_WIDTH-1:0] a);
        request_fifo.push_back(t_in_word'{status_code: s, attempt_count: a});
    endtask

    // every word answered and the core back at rest
    task automatic wait_quiet();
        while (request_fifo.size() != 0 || in_valid || answer_fifo.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        logic [ATTEMPT_WIDTH-1:0] ma, att;
        logic [DELAY_WIDTH-1:0]   ib, cap;
        logic [MULT_WIDTH-1:0]    mult;
        logic [RATIO_WIDTH-1:0]   ratio;
        int                       p, n, k;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values: plain doubling up to the cap, no jitter
        queue_word(STATUS_OK, 8'd0);
        queue_word(STATUS_CONN_FAIL, 8'd1);
        queue_word(STATUS_INTERNAL, 8'd2);
        queue_word(STATUS_OTHER, 8'd3);
        queue_word(STATUS_CONN_FAIL, 8'd3);
        queue_word(STATUS_INTERNAL, 8'd255);
        queue_word(STATUS_CONN_FAIL, 8'd0);
        queue_word(STATUS_INTERNAL, 8'd8);
        wait_quiet();

        // no retries at all, zero initial delay leaves the generator alone
        program_regs(8'd0, 32'd0, RST_MULTIPLIER, RST_MAX_BACKOFF, 17'd65536,
                     {$urandom, $urandom});
        queue_word(STATUS_CONN_FAIL, 8'd0);
        queue_word(STATUS_INTERNAL, 8'd5);
        queue_word(STATUS_CONN_FAIL, 8'd255);
        wait_quiet();

        // shrinking multiplier, full-scale delay, jitter ratio above one
        program_regs(8'd255, '1, 24'd32768, '1, '1, {$urandom, $urandom});
        queue_word(STATUS_CONN_FAIL, 8'd254);
        queue_word(STATUS_INTERNAL, 8'd255);
        queue_word(STATUS_OTHER, 8'd1);
        queue_word(STATUS_CONN_FAIL, 8'd20);
        queue_word(STATUS_OK, 8'd2);
        wait_quiet();

        // cap under the initial delay, largest multiplier, tiny jitter
        program_regs(8'd1, 32'd1000, '1, 32'd5, 17'd1, '1);
        queue_word(STATUS_CONN_FAIL, 8'd0);
        queue_word(STATUS_CONN_FAIL, 8'd1);
        queue_word(STATUS_INTERNAL, 8'd2);
        queue_word(STATUS_OTHER, 8'd200);
        wait_quiet();

        // zero cap forces a zero delay
        program_regs(8'd200, 32'd1, 24'd65536, 32'd0, 17'd65536, {$urandom, $urandom});
        queue_word(STATUS_CONN_FAIL, 8'd3);
        queue_word(STATUS_INTERNAL, 8'd100);
        wait_quiet();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            k = $urandom_range(0, 9);
            case (k)
                0: ma = 8'd0;
                1: ma = 8'd255;
                2: ma = 8'd1;
                3, 4, 5: ma = 8'($urandom_range(0, 255));
                default: ma = 8'($urandom_range(2, 15));
            endcase
            k = $urandom_range(0, 9);
            case (k)
                0: ib = '0;
                1: ib = '1;
                2: ib = $urandom;
                default: ib = 32'($urandom_range(1, 100000));
            endcase
            k = $urandom_range(0, 9);
            case (k)
                0: mult = 24'd65536;
                1: mult = '1;
                2: mult = 24'($urandom_range(0, 65535));
                3: mult = 24'($urandom);
                default: mult = 24'($urandom_range(65536, 262144));
            endcase
            k = $urandom_range(0, 9);
            case (k)
                0: cap = '0;
                1: cap = '1;
                2: cap = $urandom;
                default: cap = 32'($urandom_range(1000, 50_000_000));
            endcase
            k = $urandom_range(0, 9);
            case (k)
                0: ratio = '0;
                1: ratio = 17'd65536;
                2: ratio = '1;
                3: ratio = 17'($urandom_range(0, 131071));
                default: ratio = 17'($urandom_range(1, 65536));
            endcase
            program_regs(ma, ib, mult, cap, ratio, {$urandom, $urandom});

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            if (p == 0) pressure_token++;

            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                // mostly short attempt counts; long ones make the growth loop slow
                k = $urandom_range(0, 99);
                if (k < 5) att = 8'd0;
                else if (k < 85) att = 8'($urandom_range(1, 12));
                else if (k < 95) att = 8'($urandom_range(13, 64));
                else att = 8'($urandom_range(65, 255));
                queue_word(t_status'($urandom_range(0, 3)), att);
            end
            wait_quiet();
        end

        if (answer_fifo.size() != 0) begin
            $error("%0d result words never arrived", answer_fifo.size());
            error_count++;
        end
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: files.f
design/rbj_pkg.sv
design/rbj_serial_mul.sv
design/rbj_cfg_regs.sv
design/rbj_engine.sv
design/retry_backoff_jitter_core.sv
tb/retry_backoff_jitter_core_tb.sv
